/* sv/rtcm3fs_pkg.sv */
package rtcm3fs_pkg;

    // Fixed framing constants
    localparam logic [7:0]  PREAMBLE          = 8'hD3;
    localparam logic [24:0] CRC24Q_POLY       = 25'h1864CFB;
    localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd250;
    localparam logic [10:0] FRAME_OVERHEAD    = 11'd6;
    localparam logic [9:0]  MIN_PAYLOAD       = 10'd2;

    // Byte positions within a frame (count after the byte is taken)
    localparam logic [10:0] POS_IDLE    = 11'd0;
    localparam logic [10:0] POS_START   = 11'd1;
    localparam logic [10:0] POS_LEN_HI  = 11'd2;
    localparam logic [10:0] POS_LEN_LO  = 11'd3;
    localparam logic [10:0] POS_TYPE_HI = 11'd4;
    localparam logic [10:0] POS_TYPE_LO = 11'd5;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic        consumed;
        logic [7:0]  echo_byte;
        logic        frame_start;
        logic        frame_done;
        logic        frame_good;
        logic        frame_error;
        logic [11:0] msg_type;
        logic [10:0] frame_len;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } out_item_t;

    // Queue entry: raw beat plus its preamble class
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] time_ms;
        logic        is_preamble;
    } fe_item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic     valid;
        fe_item_t item;
    } fe_head_t;

    // CRC-24Q over one byte, MSB first
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [24:0] c;
        int          i;
        c = {1'b0, crc ^ {b, 16'h0000}};
        for (i = 0; i < 8; i++)
        begin
            c = {c[23:0], 1'b0};
            if (c[24])
            begin
                c = c ^ CRC24Q_POLY;
            end
        end
        return c[23:0];
    endfunction

endpackage

/* sv/rtcm3fs_stream_if.sv */
interface rtcm3fs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/rtcm3fs_front.sv */
module rtcm3fs_front (
    input  logic                   clk,
    input  logic                   rst_n,
    rtcm3fs_stream_if.sink         bytes,
    output rtcm3fs_pkg::fe_head_t  head,
    input  logic                   pop
);

    localparam int DEPTH = 2;

    rtcm3fs_pkg::fe_item_t entry_reg [DEPTH];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            count_reg, count_next;
    logic                  push;
    logic                  do_pop;
    rtcm3fs_pkg::fe_item_t new_entry;

    assign bytes.ready = (count_reg != 2'(DEPTH));
    assign push        = bytes.valid && bytes.ready;
    assign do_pop      = pop && (count_reg != 2'd0);

    // classify on entry
    always_comb
    begin
        new_entry.data_byte   = bytes.payload.data_byte;
        new_entry.time_ms     = bytes.payload.time_ms;
        new_entry.is_preamble = (bytes.payload.data_byte == rtcm3fs_pkg::PREAMBLE);
    end

    always_comb
    begin
        wr_ptr_next = push   ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

/* sv/rtcm3fs_back.sv */
module rtcm3fs_back #(
    parameter int MAX_FRAME_BYTES = 1029
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  rtcm3fs_pkg::fe_head_t head,
    output logic                  pop,
    rtcm3fs_stream_if.source      results
);

    localparam logic [10:0] MAX_LEN = 11'(MAX_FRAME_BYTES);

    logic [15:0]            gap_reg;
    logic [10:0]            pos_reg, pos_next;
    logic [10:0]            exp_reg, exp_next;
    logic [1:0]             lenhi_reg, lenhi_next;
    logic [31:0]            last_reg, last_next;
    logic [23:0]            crc_reg, crc_next;
    logic [11:0]            type_reg, type_next;
    logic [31:0]            good_reg, good_next;
    logic [31:0]            bad_reg, bad_next;
    logic                   out_valid_reg, out_valid_next;
    rtcm3fs_pkg::out_item_t out_reg, out_next;

    logic        adv;
    logic [31:0] gap;
    logic        timeout;
    logic [10:0] pos_eff;
    logic [10:0] pos_inc;
    logic [9:0]  payload_len;
    logic [10:0] total;
    logic [7:0]  b;
    logic        bad_inc;
    logic        good_inc;

    assign adv = head.valid && (!out_valid_reg || results.ready);
    assign pop = adv;
    assign b   = head.item.data_byte;

    assign gap         = head.item.time_ms - last_reg;
    assign timeout     = (pos_reg != rtcm3fs_pkg::POS_IDLE) && (gap > {16'h0000, gap_reg});
    assign pos_eff     = timeout ? rtcm3fs_pkg::POS_IDLE : pos_reg;
    assign pos_inc     = pos_reg + 11'd1;
    assign payload_len = {lenhi_reg, b};
    assign total       = {1'b0, payload_len} + rtcm3fs_pkg::FRAME_OVERHEAD;

    always_comb
    begin
        pos_next   = pos_reg;
        exp_next   = exp_reg;
        lenhi_next = lenhi_reg;
        last_next  = last_reg;
        crc_next   = crc_reg;
        type_next  = type_reg;
        bad_inc    = timeout;
        good_inc   = 1'b0;

        out_next             = out_reg;
        out_next.consumed    = 1'b0;
        out_next.echo_byte   = b;
        out_next.frame_start = 1'b0;
        out_next.frame_done  = 1'b0;
        out_next.frame_good  = 1'b0;
        out_next.frame_error = timeout;
        out_next.frame_len   = 11'd0;

        if (timeout)
        begin
            pos_next = rtcm3fs_pkg::POS_IDLE;
            exp_next = 11'd0;
        end

        if (pos_eff == rtcm3fs_pkg::POS_IDLE)
        begin
            if (head.item.is_preamble)
            begin
                pos_next             = rtcm3fs_pkg::POS_START;
                exp_next             = 11'd0;
                lenhi_next           = 2'd0;
                last_next            = head.item.time_ms;
                crc_next             = rtcm3fs_pkg::crc24q_byte(24'h000000, b);
                type_next            = 12'h000;
                out_next.consumed    = 1'b1;
                out_next.frame_start = 1'b1;
                out_next.frame_len   = rtcm3fs_pkg::POS_START;
            end
        end
        else
        begin
            out_next.consumed = 1'b1;
            last_next         = head.item.time_ms;
            if (pos_reg >= MAX_LEN)
            begin
                // overflow: count held is reported
                out_next.frame_len   = pos_reg;
                pos_next             = rtcm3fs_pkg::POS_IDLE;
                exp_next             = 11'd0;
                bad_inc              = 1'b1;
                out_next.frame_error = 1'b1;
            end
            else
            begin
                pos_next           = pos_inc;
                out_next.frame_len = pos_inc;
                crc_next           = rtcm3fs_pkg::crc24q_byte(crc_reg, b);
                if (pos_inc == rtcm3fs_pkg::POS_LEN_HI)
                begin
                    lenhi_next = b[1:0];
                end
                else if (pos_inc == rtcm3fs_pkg::POS_LEN_LO)
                begin
                    exp_next = total;
                    if (payload_len < rtcm3fs_pkg::MIN_PAYLOAD || total > MAX_LEN)
                    begin
                        pos_next             = rtcm3fs_pkg::POS_IDLE;
                        exp_next             = 11'd0;
                        bad_inc              = 1'b1;
                        out_next.frame_error = 1'b1;
                    end
                end
                else
                begin
                    if (pos_inc == rtcm3fs_pkg::POS_TYPE_HI)
                    begin
                        type_next = {b, 4'h0};
                    end
                    else if (pos_inc == rtcm3fs_pkg::POS_TYPE_LO)
                    begin
                        type_next = type_reg | {8'h00, b[7:4]};
                    end
                    if (exp_reg != 11'd0 && pos_inc == exp_reg)
                    begin
                        out_next.frame_done = 1'b1;
                        if (crc_next == 24'h000000)
                        begin
                            out_next.frame_good = 1'b1;
                            good_inc            = 1'b1;
                        end
                        else
                        begin
                            bad_inc              = 1'b1;
                            out_next.frame_error = 1'b1;
                        end
                        pos_next = rtcm3fs_pkg::POS_IDLE;
                        exp_next = 11'd0;
                    end
                end
            end
        end

        good_next            = good_reg + 32'(good_inc);
        bad_next             = bad_reg + 32'(bad_inc);
        out_next.msg_type    = type_next;
        out_next.good_frames = good_next;
        out_next.bad_frames  = bad_next;
    end

    always_comb
    begin
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= rtcm3fs_pkg::GAP_TIMEOUT_RESET;
            pos_reg       <= rtcm3fs_pkg::POS_IDLE;
            exp_reg       <= 11'd0;
            lenhi_reg     <= 2'd0;
            last_reg      <= 32'd0;
            crc_reg       <= 24'h000000;
            type_reg      <= 12'h000;
            good_reg      <= 32'd0;
            bad_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                gap_reg <= cfg_wr_data;
            end
            if (adv)
            begin
                pos_reg   <= pos_next;
                exp_reg   <= exp_next;
                lenhi_reg <= lenhi_next;
                last_reg  <= last_next;
                crc_reg   <= crc_next;
                type_reg  <= type_next;
                good_reg  <= good_next;
                bad_reg   <= bad_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

    a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.frame_start |->
            out_reg.consumed && out_reg.frame_len == rtcm3fs_pkg::POS_START)
        else $error("frame start without a one-byte frame");

    a_good_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.frame_good |-> out_reg.frame_done && !out_reg.frame_error)
        else $error("good flag outside a completed frame");

    a_one_count_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (good_reg == $past(good_reg) && bad_reg == $past(bad_reg))
             || (good_reg == $past(good_reg) + 32'd1 && bad_reg == $past(bad_reg))
             || (good_reg == $past(good_reg) && bad_reg == $past(bad_reg) + 32'd1))
        else $error("counters moved by more than one frame");

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MAX_LEN)
        else $error("byte position past maximum frame size");

endmodule

/* sv/rtcm3_frame_sync_core.sv */
// RTCM3 frame sync core. Every received byte beat (data byte plus a
// millisecond timestamp) produces exactly one result beat: the byte echoed,
// whether the framer took it or it belongs to the text path, start/done/good/
// error flags, the 12-bit message type, bytes of the frame so far and the
// wrapping good and bad frame counters. While hunting only preamble 0xD3 is
// taken; a frame is length-checked at its third byte and CRC-24Q checked as a
// zero residue over the whole frame. A frame whose inter-byte gap exceeds
// gap_timeout_ms is dropped and counted bad, and the late byte may open a new
// frame. Throughput is one byte per clock while results are taken: a two-beat
// queue at the input decouples intake from the framer, and the framer updates
// all its state per byte (one 32-bit gap subtract and compare plus the 8-bit
// CRC step). A byte is registered in the queue, then in the result register.
// The user must write gap_timeout_ms through cfg_wr_en/cfg_wr_data only while
// the block is idle; the block does not enforce this. It resets to 250.
module rtcm3_frame_sync_core #(
    parameter int MAX_FRAME_BYTES = 1029
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    rtcm3fs_stream_if.sink    bytes,
    rtcm3fs_stream_if.source  results
);

    // queue head handed to the framer, and its pop strobe
    rtcm3fs_pkg::fe_head_t head;
    logic                  pop;

    // intake: accept and classify beats into the queue
    rtcm3fs_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .head  (head),
        .pop   (pop)
    );

    // framer: state update, counters and registered result beat
    rtcm3fs_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .pop         (pop),
        .results     (results)
    );

endmodule

/* sim/tb_rtcm3_frame_sync_core.sv */
module tb_rtcm3_frame_sync_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_MAX      = 1029;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    rtcm3fs_stream_if #(.T(rtcm3fs_pkg::in_item_t))  bytes_if ();
    rtcm3fs_stream_if #(.T(rtcm3fs_pkg::out_item_t)) results_if ();

    rtcm3_frame_sync_core #(
        .MAX_FRAME_BYTES(FRAME_MAX)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .bytes      (bytes_if),
        .results    (results_if)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Framer shadow state. Mirrors the block after each accepted beat;
    // gap_limit is the shadow of the one config register.
    // ------------------------------------------------------------------
    logic [15:0] gap_limit = rtcm3fs_pkg::GAP_TIMEOUT_RESET;
    logic [10:0] pos_q     = rtcm3fs_pkg::POS_IDLE;
    logic [10:0] total_q   = '0;
    logic [1:0]  len_hi_q  = '0;
    logic [31:0] last_ms_q = '0;
    logic [23:0] crc_q     = '0;
    logic [11:0] type_q    = '0;
    logic [31:0] good_q    = '0;
    logic [31:0] bad_q     = '0;

    rtcm3fs_pkg::in_item_t  rx_backlog[$];        // byte beats waiting to be driven
    rtcm3fs_pkg::out_item_t pending_outcomes[$];  // predicted result beats, oldest first
    logic [7:0]             frame_buf[$];         // scratch frame under construction

    // stimulus knobs
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [31:0] stamp_ms = '0;
    bit          late_next = 1'b0;

    // bookkeeping
    int          mismatches = 0;
    int          beats_in = 0;
    int          text_beats = 0;
    int          beats_out = 0;
    int          cfg_writes = 0;
    int          idle_cycles = 0;
    rtcm3fs_pkg::out_item_t expected_beat;

    // CRC-24Q, one bit at a time with the feedback taken before the shift
    function automatic logic [23:0] crc24q_next(logic [23:0] c, logic [7:0] d);
        logic [23:0] r;
        logic        fb;
        int          k;
        r = c;
        for (k = 7; k >= 0; k--)
        begin
            fb = r[23] ^ d[k];
            r  = {r[22:0], 1'b0};
            if (fb)
            begin
                r = r ^ rtcm3fs_pkg::CRC24Q_POLY[23:0];
            end
        end
        return r;
    endfunction

    // Advance the framer shadow by one byte beat and return its result beat.
    function automatic rtcm3fs_pkg::out_item_t frame_byte_outcome(rtcm3fs_pkg::in_item_t beat);
        rtcm3fs_pkg::out_item_t res;
        logic [9:0]             plen;
        res = '0;
        res.echo_byte = beat.data_byte;

        // open frame went stale: drop it, then handle the byte as if hunting
        if (pos_q != rtcm3fs_pkg::POS_IDLE
            && (beat.time_ms - last_ms_q) > {16'h0000, gap_limit})
        begin
            pos_q           = rtcm3fs_pkg::POS_IDLE;
            total_q         = '0;
            bad_q           = bad_q + 1;
            res.frame_error = 1'b1;
        end

        if (pos_q == rtcm3fs_pkg::POS_IDLE)
        begin
            if (beat.data_byte == rtcm3fs_pkg::PREAMBLE)
            begin
                pos_q           = rtcm3fs_pkg::POS_START;
                total_q         = '0;
                len_hi_q        = '0;
                last_ms_q       = beat.time_ms;
                crc_q           = crc24q_next(24'h000000, beat.data_byte);
                type_q          = '0;
                res.consumed    = 1'b1;
                res.frame_start = 1'b1;
                res.frame_len   = rtcm3fs_pkg::POS_START;
            end
        end
        else
        begin
            res.consumed = 1'b1;
            last_ms_q    = beat.time_ms;
            if (pos_q >= FRAME_MAX)
            begin
                // overflow: report what was held, then drop
                res.frame_len   = pos_q;
                pos_q           = rtcm3fs_pkg::POS_IDLE;
                total_q         = '0;
                bad_q           = bad_q + 1;
                res.frame_error = 1'b1;
            end
            else
            begin
                pos_q         = pos_q + 11'd1;
                res.frame_len = pos_q;
                crc_q         = crc24q_next(crc_q, beat.data_byte);
                if (pos_q == rtcm3fs_pkg::POS_LEN_HI)
                begin
                    len_hi_q = beat.data_byte[1:0];
                end
                else if (pos_q == rtcm3fs_pkg::POS_LEN_LO)
                begin
                    plen    = {len_hi_q, beat.data_byte};
                    total_q = {1'b0, plen} + rtcm3fs_pkg::FRAME_OVERHEAD;
                    if (plen < rtcm3fs_pkg::MIN_PAYLOAD || total_q > FRAME_MAX)
                    begin
                        pos_q           = rtcm3fs_pkg::POS_IDLE;
                        total_q         = '0;
                        bad_q           = bad_q + 1;
                        res.frame_error = 1'b1;
                    end
                end
                else
                begin
                    if (pos_q == rtcm3fs_pkg::POS_TYPE_HI)
                    begin
                        type_q = {beat.data_byte, 4'h0};
                    end
                    else if (pos_q == rtcm3fs_pkg::POS_TYPE_LO)
                    begin
                        type_q[3:0] = beat.data_byte[7:4];
                    end
                    if (total_q != '0 && pos_q == total_q)
                    begin
                        res.frame_done = 1'b1;
                        if (crc_q == 24'h000000)
                        begin
                            res.frame_good = 1'b1;
                            good_q         = good_q + 1;
                        end
                        else
                        begin
                            bad_q           = bad_q + 1;
                            res.frame_error = 1'b1;
                        end
                        pos_q   = rtcm3fs_pkg::POS_IDLE;
                        total_q = '0;
                    end
                end
            end
        end

        res.msg_type    = type_q;
        res.good_frames = good_q;
        res.bad_frames  = bad_q;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0d ns: result beat %0d %s expected 0x%0h, got 0x%0h",
                     $time, beats_out, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders. Gaps are picked against the current gap limit so
    // that bytes land just inside, exactly on, and just past it.
    // ------------------------------------------------------------------
    function automatic int pick_gap(int drop_pct);
        int roll;
        roll = $urandom_range(99);
        if (late_next || roll < drop_pct)
        begin
            late_next = 1'b0;
            return int'(gap_limit) + 1 + $urandom_range(2);
        end
        if (roll < 2 * drop_pct)
        begin
            return int'(gap_limit);
        end
        return $urandom_range(gap_limit < 16'd3 ? int'(gap_limit) : 3);
    endfunction

    function automatic void push_beat(logic [7:0] d, int gap);
        rtcm3fs_pkg::in_item_t it;
        stamp_ms     = stamp_ms + gap;
        it.data_byte = d;
        it.time_ms   = stamp_ms;
        rx_backlog.push_back(it);
    endfunction

    function automatic void emit_frame(int n, int drop_pct);
        int k;
        for (k = 0; k < n; k++)
        begin
            push_beat(frame_buf[k], pick_gap(drop_pct));
        end
    endfunction

    // Well-formed frame: preamble, length, payload led by the message type,
    // CRC appended so the residue over the whole frame is zero.
    function automatic void make_frame(int plen, logic [11:0] mtype);
        logic [23:0] c;
        logic [7:0]  d;
        logic [5:0]  junk;
        int          k;
        frame_buf.delete();
        junk = 6'($urandom_range(63));
        frame_buf.push_back(rtcm3fs_pkg::PREAMBLE);
        frame_buf.push_back({junk, plen[9:8]});
        frame_buf.push_back(plen[7:0]);
        for (k = 0; k < plen; k++)
        begin
            if (k == 0)
            begin
                d = mtype[11:4];
            end
            else if (k == 1)
            begin
                d      = 8'($urandom_range(255));
                d[7:4] = mtype[3:0];
            end
            else if ($urandom_range(9) == 0)
            begin
                d = rtcm3fs_pkg::PREAMBLE;   // preamble value buried in the payload
            end
            else
            begin
                d = 8'($urandom_range(255));
            end
            frame_buf.push_back(d);
        end
        c = '0;
        foreach (frame_buf[k])
        begin
            c = crc24q_next(c, frame_buf[k]);
        end
        frame_buf.push_back(c[23:16]);
        frame_buf.push_back(c[15:8]);
        frame_buf.push_back(c[7:0]);
    endfunction

    // Block is idle once nothing is queued, in flight or owed.
    task automatic wait_idle();
        while (rx_backlog.size() != 0 || bytes_if.valid || pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_gap_limit(logic [15:0] v);
        wait_idle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        gap_limit   = v;
        cfg_writes++;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly clean frames with random content; the rest is corrupted,
    // truncated and badly sized frames, text noise and clock jumps.
    task automatic random_phase(int target, bit pause_midway);
        int         made;
        int         kind;
        int         plen;
        int         n;
        int         k;
        logic [7:0] mask;
        logic [5:0] junk;
        made = 0;
        while (made < target)
        begin
            if (pause_midway && made >= target / 2)
            begin
                // let the block drain completely before going on
                wait_idle();
                pause_midway = 1'b0;
            end
            kind = $urandom_range(99);
            plen = ($urandom_range(49) == 0) ? $urandom_range(21, 80) : $urandom_range(2, 20);
            if (kind < 55)
            begin
                make_frame(plen, 12'($urandom_range(4095)));
                emit_frame(frame_buf.size(), 2);
                made += frame_buf.size();
            end
            else if (kind < 67)
            begin
                // one flipped bit after the length field: CRC fails
                make_frame(plen, 12'($urandom_range(4095)));
                k    = $urandom_range(3, frame_buf.size() - 1);
                mask = 8'h01 << $urandom_range(7);
                frame_buf[k] = frame_buf[k] ^ mask;
                emit_frame(frame_buf.size(), 2);
                made += frame_buf.size();
            end
            else if (kind < 75)
            begin
                // cut short; the first byte of the next frame arrives late and kills it
                make_frame(plen, 12'($urandom_range(4095)));
                n = $urandom_range(1, frame_buf.size() - 1);
                emit_frame(n, 0);
                late_next = 1'b1;
                made += n;
            end
            else if (kind < 83)
            begin
                // payload of 0 or 1 byte
                junk = 6'($urandom_range(63));
                frame_buf.delete();
                frame_buf.push_back(rtcm3fs_pkg::PREAMBLE);
                frame_buf.push_back({junk, 2'b00});
                frame_buf.push_back(8'($urandom_range(1)));
                emit_frame(3, 2);
                made += 3;
            end
            else if (kind < 95)
            begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                begin
                    push_beat(8'($urandom_range(255)), $urandom_range(3));
                end
            end
            else if ($urandom_range(1) == 0)
            begin
                stamp_ms = $urandom();
            end
            else
            begin
                stamp_ms = 32'hFFFF_FFFF - $urandom_range(3);   // about to wrap
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: keeps a byte beat on the bus until it is taken, predicts the
    // result at acceptance, and idles at random between beats.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            bytes_if.valid <= 1'b0;
        end
        else
        begin
            if (bytes_if.valid && bytes_if.ready)
            begin
                pending_outcomes.push_back(frame_byte_outcome(bytes_if.payload));
                beats_in++;
                if (!pending_outcomes[pending_outcomes.size() - 1].consumed)
                begin
                    text_beats++;
                end
            end
            if (!bytes_if.valid || bytes_if.ready)
            begin
                if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    bytes_if.payload <= rx_backlog.pop_front();
                    bytes_if.valid   <= 1'b1;
                end
                else
                begin
                    bytes_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result beat is matched against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    mismatches++;
                    $display("%0d ns: result beat with nothing expected, got %p",
                             $time, results_if.payload);
                end
                else
                begin
                    expected_beat = pending_outcomes.pop_front();
                    check_field("consumed",    expected_beat.consumed,
                                results_if.payload.consumed);
                    check_field("echo_byte",   expected_beat.echo_byte,
                                results_if.payload.echo_byte);
                    check_field("frame_start", expected_beat.frame_start,
                                results_if.payload.frame_start);
                    check_field("frame_done",  expected_beat.frame_done,
                                results_if.payload.frame_done);
                    check_field("frame_good",  expected_beat.frame_good,
                                results_if.payload.frame_good);
                    check_field("frame_error", expected_beat.frame_error,
                                results_if.payload.frame_error);
                    check_field("msg_type",    expected_beat.msg_type,
                                results_if.payload.msg_type);
                    check_field("frame_len",   expected_beat.frame_len,
                                results_if.payload.frame_len);
                    check_field("good_frames", expected_beat.good_frames,
                                results_if.payload.good_frames);
                    check_field("bad_frames",  expected_beat.bad_frames,
                                results_if.payload.bad_frames);
                end
                beats_out++;
            end
            results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long without a beat on either side ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (bytes_if.valid && bytes_if.ready)
                   || (results_if.valid && results_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0d ns: no beat moved for %0d cycles, %0d results still owed",
                     $time, idle_cycles, pending_outcomes.size());
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed corners at the reset gap limit, then random
    // phases across limits and idling modes.
    // ------------------------------------------------------------------
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        bytes_if.valid   = 1'b0;
        bytes_if.payload = '0;
        results_if.ready = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // text bytes while hunting
        stamp_ms = 32'd1000;
        push_beat(8'h00, 0);
        push_beat(8'hFF, 1);
        // smallest legal frame, all-ones message type
        make_frame(2, 12'hFFF);
        emit_frame(frame_buf.size(), 0);
        // payload of one byte, junk in the upper length bits
        push_beat(rtcm3fs_pkg::PREAMBLE, 5);
        push_beat(8'hFC, 1);
        push_beat(8'h01, 1);
        // CRC failure on the last byte
        make_frame(2, 12'h000);
        frame_buf[7] = frame_buf[7] ^ 8'h01;
        emit_frame(frame_buf.size(), 0);
        // gaps across the 32-bit wrap: late preamble reopens, on-limit byte
        // stays in, late non-preamble byte falls to text
        stamp_ms = 32'hFFFF_FFF0;
        push_beat(rtcm3fs_pkg::PREAMBLE, 0);
        push_beat(8'h00, 5);
        push_beat(8'h02, 20);
        push_beat(rtcm3fs_pkg::PREAMBLE, 251);
        push_beat(8'h00, 250);
        push_beat(8'h55, 251);

        set_gap_limit(16'd250);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_phase(55, 1'b1);

        set_gap_limit(16'd0);
        send_idle_pct  = 62;
        recv_stall_pct = 0;
        random_phase(55, 1'b0);

        // widest limit, plus one longer frame
        set_gap_limit(16'hFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        make_frame(40, 12'($urandom_range(4095)));
        emit_frame(frame_buf.size(), 0);
        random_phase(55, 1'b0);

        set_gap_limit(16'($urandom_range(2, 65534)));
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        random_phase(55, 1'b0);

        set_gap_limit(16'd1);
        send_idle_pct  = 62;
        recv_stall_pct = 0;
        random_phase(55, 1'b0);

        set_gap_limit(16'd250);
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        random_phase(55, 1'b0);

        // drain, then leave room for any stray result beat
        wait_idle();
        repeat (20) @(posedge clk);

        $display("Checked %0d byte beats (%0d left to text) against %0d result beats",
                 beats_in, text_beats, beats_out);
        $display("Frames: %0d good, %0d bad; %0d gap-limit writes, four idling modes",
                 good_q, bad_q, cfg_writes);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
